// ===== sv/spq_pkg.sv =====
`timescale 1ns / 1ps
package spq_pkg;

    // Entry store geometry.
    localparam int CAPACITY      = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int PAYLOAD_BITS  = 32;
    localparam int IDX_BITS      = $clog2(CAPACITY);
    localparam int CNT_BITS      = $clog2(CAPACITY + 1);

    // Widths of the fields at the ports.
    localparam int REQ_FIELD_BITS  = 1;
    localparam int PRIO_FIELD_BITS = 8;
    localparam int PAY_FIELD_BITS  = 32;
    localparam int STAT_FIELD_BITS = 2;
    localparam int OCC_FIELD_BITS  = 5;

    // Depth of the command queue between the front and the back.
    localparam int CMD_DEPTH    = 2;
    localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);

    typedef logic [PRIORITY_BITS-1:0]   prio_t;
    typedef logic [PAYLOAD_BITS-1:0]    pay_t;
    typedef logic [STAT_FIELD_BITS-1:0] status_t;
    typedef logic [REQ_FIELD_BITS-1:0]  req_t;

    localparam req_t REQ_INSERT = 1'b0;
    localparam req_t REQ_POP    = 1'b1;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    // One classified command as it travels from the front to the back.
    typedef struct packed {
        logic  is_pop;
        prio_t prio;
        pay_t  payload;
    } cmd_t;

    // One finished result as held for the output side.
    typedef struct packed {
        status_t                  status;
        prio_t                    prio;
        pay_t                     payload;
        logic [CNT_BITS-1:0]      occupancy;
    } res_t;

    // Handshake status between the command queue and its neighbors.
    typedef struct packed {
        logic valid;
        logic ready;
    } link_t;

endpackage

// ===== sv/spq_front.sv =====
`timescale 1ns / 1ps
module spq_front
    import spq_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  req_t                       req_type,
    input  logic [PRIO_FIELD_BITS-1:0] entry_priority,
    input  logic [PAY_FIELD_BITS-1:0]  entry_payload,
    output cmd_t                       cmd,
    input  logic                       cmd_ready,
    output logic                       cmd_valid
);

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_cmd_reg;
    cmd_t hold_cmd_next;
    logic take;

    // The holding stage is busy only while the command queue refuses it.
    assign full = hold_valid_reg && !cmd_ready;
    assign take = push && !full;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (!full)
        begin
            hold_valid_next = push;
        end
        hold_cmd_next = hold_cmd_reg;
        if (take)
        begin
            hold_cmd_next.is_pop  = (req_type == REQ_POP);
            hold_cmd_next.prio    = PRIORITY_BITS'(entry_priority);
            hold_cmd_next.payload = PAYLOAD_BITS'(entry_payload);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_cmd_reg <= hold_cmd_next;
    end

    assign cmd       = hold_cmd_reg;
    assign cmd_valid = hold_valid_reg;

endmodule

// ===== sv/spq_cmd_fifo.sv =====
`timescale 1ns / 1ps
module spq_cmd_fifo
    import spq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  wr_cmd,
    input  logic  wr_valid,
    output logic  wr_ready,
    output cmd_t  rd_cmd,
    output link_t rd_link,
    input  logic  rd_ready
);

    cmd_t                    mem_reg [CMD_DEPTH];
    logic [CMD_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    do_wr;
    logic                    do_rd;

    assign wr_ready      = (cnt_reg != CMD_CNT_BITS'(CMD_DEPTH));
    assign rd_link.valid = (cnt_reg != '0);
    assign rd_link.ready = wr_ready;
    assign rd_cmd        = mem_reg[rd_ptr_reg];

    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_link.valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_BITS'(CMD_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_BITS'(CMD_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ===== sv/spq_back.sv =====
`timescale 1ns / 1ps
module spq_back
    import spq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  link_t               cmd_link,
    output logic                cmd_ready,
    output res_t                res,
    output logic                res_valid,
    input  logic                res_pop,
    output logic [CNT_BITS-1:0] count
);

    prio_t               slot_prio_reg [CAPACITY];
    prio_t               slot_prio_next [CAPACITY];
    pay_t                slot_pay_reg [CAPACITY];
    pay_t                slot_pay_next [CAPACITY];
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                res_valid_reg, res_valid_next;
    res_t                res_reg, res_next;
    logic [CAPACITY-1:0] ge;
    logic                exec;
    logic                is_full;
    logic                is_empty;

    // A command runs when the result register is free or is drained this cycle.
    assign cmd_ready = !res_valid_reg || res_pop;
    assign exec      = cmd_link.valid && cmd_ready;
    assign is_full   = (count_reg == CNT_BITS'(CAPACITY));
    assign is_empty  = (count_reg == '0);

    // Slots are sorted by descending priority, so ge is a prefix of ones.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            ge[i] = (CNT_BITS'(i) < count_reg) && (slot_prio_reg[i] >= cmd.prio);
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            slot_prio_next[i] = slot_prio_reg[i];
            slot_pay_next[i]  = slot_pay_reg[i];
        end
        count_next     = count_reg;
        res_valid_next = res_valid_reg && !res_pop;
        res_next       = res_reg;
        if (exec)
        begin
            res_valid_next   = 1'b1;
            res_next.status  = ST_OK;
            res_next.prio    = '0;
            res_next.payload = '0;
            if (!cmd.is_pop)
            begin
                if (is_full)
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    if (!ge[0])
                    begin
                        slot_prio_next[0] = cmd.prio;
                        slot_pay_next[0]  = cmd.payload;
                    end
                    for (int i = 1; i < CAPACITY; i++)
                    begin
                        if (!ge[i])
                        begin
                            if (ge[i-1])
                            begin
                                slot_prio_next[i] = cmd.prio;
                                slot_pay_next[i]  = cmd.payload;
                            end
                            else
                            begin
                                slot_prio_next[i] = slot_prio_reg[i-1];
                                slot_pay_next[i]  = slot_pay_reg[i-1];
                            end
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                if (is_empty)
                begin
                    res_next.status = ST_EMPTY;
                end
                else
                begin
                    res_next.prio    = slot_prio_reg[0];
                    res_next.payload = slot_pay_reg[0];
                    for (int i = 0; i < CAPACITY - 1; i++)
                    begin
                        slot_prio_next[i] = slot_prio_reg[i+1];
                        slot_pay_next[i]  = slot_pay_reg[i+1];
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            res_next.occupancy = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            slot_prio_reg[i] <= slot_prio_next[i];
            slot_pay_reg[i]  <= slot_pay_next[i];
        end
        res_reg <= res_next;
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;
    assign count     = count_reg;

endmodule

// ===== sv/stable_priority_queue.sv =====
`timescale 1ns / 1ps
// A transaction accepted into the holding stage passes through the command queue and the
// sorted slot array before its result shows on the ports. Throughput: one transaction per
// cycle sustained while each result is popped as it shows, set by the combinational compare
// and shift of the sorted slot array. Reset (rst_n, asynchronous, active low) empties the
// queue; the slot contents are not cleared and are never read before they are written.
module stable_priority_queue
    import spq_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  req_t                       req_type,
    input  logic [PRIO_FIELD_BITS-1:0] entry_priority,
    input  logic [PAY_FIELD_BITS-1:0]  entry_payload,
    output logic                       empty,
    input  logic                       pop,
    output status_t                    status,
    output logic [PRIO_FIELD_BITS-1:0] out_priority,
    output logic [PAY_FIELD_BITS-1:0]  out_payload,
    output logic [OCC_FIELD_BITS-1:0]  occupancy
);

    // The front stage registers each request transaction and classifies it as an
    // insert or a pop. It only reports full while its holding register is occupied
    // and the command queue cannot take that command.
    cmd_t                front_cmd;
    logic                front_valid;
    logic                fifo_wr_ready;
    cmd_t                back_cmd;
    link_t               back_link;
    logic                back_ready;
    res_t                back_res;
    logic                back_res_valid;
    logic [CNT_BITS-1:0] back_count;

    spq_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .req_type       (req_type),
        .entry_priority (entry_priority),
        .entry_payload  (entry_payload),
        .cmd            (front_cmd),
        .cmd_ready      (fifo_wr_ready),
        .cmd_valid      (front_valid)
    );

    // A short command queue lets the front keep taking transactions while the back
    // waits for its result register to be drained.
    spq_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cmd   (front_cmd),
        .wr_valid (front_valid),
        .wr_ready (fifo_wr_ready),
        .rd_cmd   (back_cmd),
        .rd_link  (back_link),
        .rd_ready (back_ready)
    );

    // The back keeps the entries sorted by descending priority, oldest first among
    // equal priorities. An insert lands behind every entry of equal or higher
    // priority, and a pop takes the head and moves the rest up one slot.
    spq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_link  (back_link),
        .cmd_ready (back_ready),
        .res       (back_res),
        .res_valid (back_res_valid),
        .res_pop   (pop),
        .count     (back_count)
    );

    // The result register is the head of the output queue.
    assign empty        = !back_res_valid;
    assign status       = back_res.status;
    assign out_priority = PRIO_FIELD_BITS'(back_res.prio);
    assign out_payload  = PAY_FIELD_BITS'(back_res.payload);
    assign occupancy    = OCC_FIELD_BITS'(back_res.occupancy);

    // The stored entry count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        back_count <= CNT_BITS'(CAPACITY))
        else $error("entry count exceeds capacity");

    // A refused insert is only reported when every slot is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_FULL) |-> occupancy == OCC_FIELD_BITS'(CAPACITY))
        else $error("full status with free slots");

    // A pop on an empty queue carries zero fields and zero occupancy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_EMPTY)
            |-> (occupancy == '0 && out_priority == '0 && out_payload == '0))
        else $error("empty status with nonzero fields");

    // A waiting result that is not taken stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(occupancy)))
        else $error("waiting result changed");

endmodule
